// ===== rtl/ycs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycs_pkg
// Shared types, constants and a helper function for the YCoCg pixel converter.
// ----------------------------------------------------------------------------
package ycs_pkg;

    localparam int FRAC_BITS = 8;
    localparam int QW        = 11 + FRAC_BITS;   // |chroma|*8*2^F width
    localparam int VW        = QW + 3;           // signed channel sum width
    localparam int TOPW      = 8 + FRAC_BITS;    // clamped channel width

    localparam logic [1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [1:0] CFG_VARIANT    = 2'd1;
    localparam logic [1:0] CFG_COLOR_SWAP = 2'd2;

    typedef struct packed {
        logic [7:0] chan3;
        logic [7:0] chan2;
        logic [7:0] chan1;
        logic [7:0] chan0;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out3;
        logic [7:0] out2;
        logic [7:0] out1;
        logic [7:0] out0;
    } pix_out_t;

    // bytes and chroma signs that travel alongside the divider
    typedef struct packed {
        logic [7:0] c3;
        logic [7:0] c1;
        logic [7:0] c0;
        logic       co_neg;
        logic       cg_neg;
    } side_t;

    // round(sqrt(255*v)) exactly, computed by a counting loop
    function automatic logic [7:0] gamma_root(input logic [7:0] v);
        int r;
        r = 0;
        for (int k = 0; k < 255; k++)
            if ((2 * k + 1) * (2 * k + 1) <= 1020 * int'(v))
                r++;
        return 8'(r);
    endfunction

endpackage

// ===== rtl/ycocg_texture_swizzle.sv =====
`timescale 1ns / 1ps
// Pipeline: the bit-per-stage chroma dividers, then stages A, B, C and the
// output register; the encode and plain decode paths ride the same pipeline.
// Throughput: one item per cycle; a stall freezes the whole pipeline.
// Reset: async active low clears valid bits and the config registers to 0.
// ----------------------------------------------------------------------------
// ycocg_texture_swizzle
// RGB <-> YCoCg (DXT5 layout) pixel converter with gamma and scaled variants.
// ----------------------------------------------------------------------------
module ycocg_texture_swizzle
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  ycs_pkg::pix_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ycs_pkg::pix_out_t out_data
);
    import ycs_pkg::*;

    logic       dir_reg, swap_reg;
    logic [1:0] var_reg;
    logic       gam, scaled, en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b0;
            var_reg  <= 2'd0;
            swap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTION:  dir_reg  <= cfg_data[0];
                CFG_VARIANT:    var_reg  <= cfg_data;
                CFG_COLOR_SWAP: swap_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign gam    = var_reg[0];
    assign scaled = var_reg[1];

    // out_valid register acts as the stall point; hold everything on stall
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // stage 1: capture, gamma roots and chroma magnitudes into the divider
    logic [7:0]    e0, e1, e2;
    logic [8:0]    mco, mcg;
    logic [QW-1:0] nco, ncg;
    side_t         sb, sbo;
    logic          dv0, dv1;
    logic [QW-1:0] qco, qcg;
    side_t         sbo1;

    always_comb
    begin
        e0 = (gam && !dir_reg) ? gamma_root(in_data.chan0) : in_data.chan0;
        e1 = (gam && !dir_reg) ? gamma_root(in_data.chan1) : in_data.chan1;
        e2 = (gam && !dir_reg) ? gamma_root(in_data.chan2) : in_data.chan2;
        mco = in_data.chan0[7] ? {1'b0, in_data.chan0} - 9'd128 : 9'd128 - {1'b0, in_data.chan0};
        mcg = in_data.chan1[7] ? {1'b0, in_data.chan1} - 9'd128 : 9'd128 - {1'b0, in_data.chan1};
        nco = QW'(mco) << (3 + FRAC_BITS);
        ncg = QW'(mcg) << (3 + FRAC_BITS);
        sb.c0 = dir_reg ? in_data.chan0 : e0;
        sb.c1 = dir_reg ? in_data.chan1 : e1;
        sb.c3 = dir_reg ? in_data.chan3 : e2;   // on encode carry the red side
        sb.co_neg = !in_data.chan0[7];
        sb.cg_neg = !in_data.chan1[7];
    end

    // the alpha and c2 bytes ride separate delay lines alongside
    logic [7:0] c2_pipe [QW+1];
    logic [7:0] a_pipe  [QW+1];
    assign c2_pipe[0] = in_data.chan2;
    assign a_pipe[0]  = in_data.chan3;
    for (genvar k = 0; k < QW; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c2_pipe[k+1] <= c2_pipe[k];
                a_pipe[k+1]  <= a_pipe[k];
            end
        end
    end

    ycs_divider u_div_co (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .num(nco), .den({1'b0, in_data.chan2} + 9'd8), .side_in(sb),
        .out_valid(dv0), .quot(qco), .side_out(sbo)
    );
    ycs_divider u_div_cg (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .num(ncg), .den({1'b0, in_data.chan2} + 9'd8), .side_in(sb),
        .out_valid(dv1), .quot(qcg), .side_out(sbo1)
    );

    // stage A: sums for every path
    logic              va_reg;
    logic signed [VW-1:0] sr_reg, sg_reg, sbb_reg;
    logic [9:0]        ey_reg, eco_reg, ecg_reg;
    logic [7:0]        alpha_reg, c2a_reg;
    logic signed [VW-1:0] co_s, cg_s, y_s;
    logic signed [11:0] a_s, g_s, b_s;

    always_comb
    begin
        co_s = sbo.co_neg ? -$signed({3'b0, qco}) : $signed({3'b0, qco});
        cg_s = sbo1.cg_neg ? -$signed({3'b0, qcg}) : $signed({3'b0, qcg});
        y_s  = $signed(VW'(sbo.c3) << FRAC_BITS);
        a_s  = $signed({4'd0, sbo.c0});
        g_s  = $signed({4'd0, sbo.c1});
        b_s  = $signed({4'd0, sbo.c3});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= dv0 && dv1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg <= a_pipe[QW];
            c2a_reg   <= c2_pipe[QW];
            if (!scaled)
            begin
                sr_reg  <= VW'(b_s + a_s - g_s);
                sg_reg  <= VW'(b_s + g_s - 12'sd128);
                sbb_reg <= VW'(b_s - a_s - g_s + 12'sd256);
            end
            else
            begin
                sr_reg  <= y_s + co_s - cg_s;
                sg_reg  <= y_s + cg_s;
                sbb_reg <= y_s - co_s - cg_s;
            end
            ey_reg  <= 10'(b_s + 2 * g_s + a_s + 12'sd2) >> 2;
            eco_reg <= 10'((2 * b_s - 2 * a_s + 12'sd514) >>> 2);
            ecg_reg <= 10'((2 * g_s - b_s - a_s + 12'sd514) >>> 2);
        end
    end

    // stage B: clamp
    localparam logic signed [VW-1:0] TOP = VW'(255) << FRAC_BITS;
    logic          vb_reg;
    logic [TOPW-1:0] kr_reg, kg_reg, kb_reg;
    logic [7:0]    ey2_reg, eco2_reg, ecg2_reg, alpha2_reg, c2b_reg;

    function automatic logic [TOPW-1:0] clampv(input logic signed [VW-1:0] v,
                                              input logic sc);
        logic signed [VW-1:0] t;
        t = sc ? TOP : VW'(255);
        if (v < 0) return '0;
        if (v > t) return TOPW'(t);
        return TOPW'(v);
    endfunction

    function automatic logic [7:0] sat8(input logic [9:0] v);
        return (v > 10'd255) ? 8'd255 : v[7:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kr_reg     <= clampv(sr_reg, scaled);
            kg_reg     <= clampv(sg_reg, scaled);
            kb_reg     <= clampv(sbb_reg, scaled);
            ey2_reg    <= sat8(ey_reg);
            eco2_reg   <= sat8(eco_reg);
            ecg2_reg   <= sat8(ecg_reg);
            alpha2_reg <= scaled ? 8'd0 : alpha_reg;
            c2b_reg    <= c2a_reg;
        end
    end

    // stage C: square
    logic          vc_reg;
    logic [2*TOPW-1:0] pr_reg, pg_reg, pb_reg;
    logic [7:0]    ey3_reg, eco3_reg, ecg3_reg, alpha3_reg, c2c_reg;
    logic [TOPW-1:0] kr2_reg, kg2_reg, kb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg <= kr_reg * kr_reg;
            pg_reg <= kg_reg * kg_reg;
            pb_reg <= kb_reg * kb_reg;
            kr2_reg <= kr_reg; kg2_reg <= kg_reg; kb2_reg <= kb_reg;
            ey3_reg <= ey2_reg; eco3_reg <= eco2_reg; ecg3_reg <= ecg2_reg;
            alpha3_reg <= alpha2_reg; c2c_reg <= c2b_reg;
        end
    end

    // stage D: divide squares by 255 (or 255<<2F) and assemble bytes
    localparam int PW = 2 * TOPW;
    function automatic logic [7:0] div255(input logic [PW-1:0] p, input logic sc);
        logic [PW-1:0] s;
        logic [PW+9:0] m;
        logic [PW-1:0] q;
        s = sc ? (p >> (2 * FRAC_BITS)) : p;
        // p < 2^16 after the shift except low bits; floor(p/255) via fixup
        m = ({10'd0, s} * (PW+10)'(257)) >> 16;
        q = m[PW-1:0];
        if (s - q * PW'(255) >= PW'(255)) q = q + 1'b1;
        return 8'(q);
    endfunction

    logic [7:0] o0, o1, o2, o3, t0, t2, d0, d1, d2;
    logic [PW-1:0] sr_sc, sg_sc, sb_sc;
    logic [PW-1:0] fr, fg, fb;

    always_comb
    begin
        // scaled gamma: floor(u*u / (255<<2F)) = floor(floor(u*u>>2F)/255)
        sr_sc = pr_reg; sg_sc = pg_reg; sb_sc = pb_reg;
        fr = sr_sc; fg = sg_sc; fb = sb_sc;
        if (gam)
        begin
            d0 = div255(fr, scaled);
            d1 = div255(fg, scaled);
            d2 = div255(fb, scaled);
        end
        else if (scaled)
        begin
            d0 = 8'(kr2_reg >> FRAC_BITS);
            d1 = 8'(kg2_reg >> FRAC_BITS);
            d2 = 8'(kb2_reg >> FRAC_BITS);
        end
        else
        begin
            d0 = kr2_reg[7:0];
            d1 = kg2_reg[7:0];
            d2 = kb2_reg[7:0];
        end
        if (!dir_reg)
        begin
            t0 = alpha3_reg; o1 = ecg3_reg; t2 = eco3_reg; o3 = ey3_reg;
        end
        else
        begin
            t0 = d0; o1 = d1; t2 = d2; o3 = scaled ? 8'd255 : c2c_reg;
        end
        if ((!dir_reg && !swap_reg) || (dir_reg && swap_reg))
        begin
            o0 = t2; o2 = t0;
        end
        else
        begin
            o0 = t0; o2 = t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data <= '{out3: o3, out2: o2, out1: o1, out0: o0};
    end

endmodule

// ===== rtl/ycs_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycs_divider
// Pipelined restoring divider: QW-bit unsigned numerator by 9-bit divisor,
// one quotient bit per stage, with a sideband that travels along.
// ----------------------------------------------------------------------------
module ycs_divider
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ycs_pkg::QW-1:0]  num,
    input  logic [8:0]              den,
    input  ycs_pkg::side_t          side_in,
    output logic                    out_valid,
    output logic [ycs_pkg::QW-1:0]  quot,
    output ycs_pkg::side_t          side_out
);
    import ycs_pkg::*;

    logic [QW:0]       vld_reg;
    logic [QW-1:0]     rem_reg  [QW+1];
    logic [QW-1:0]     q_reg    [QW+1];
    logic [8:0]        den_reg  [QW+1];
    side_t             sb_reg   [QW+1];

    always_comb
    begin
        rem_reg[0] = num;
        q_reg[0]   = '0;
        den_reg[0] = den;
        sb_reg[0]  = side_in;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int B = QW - 1 - i;
        logic [QW+8:0] trial;
        logic          fit;
        assign trial = {9'd0, rem_reg[i]} >> B;
        assign fit   = trial >= {{QW{1'b0}}, den_reg[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= fit ? QW'({9'd0, rem_reg[i]} - ({{QW{1'b0}}, den_reg[i]} << B))
                                    : rem_reg[i];
                q_reg[i+1]   <= q_reg[i] | (QW'(fit) << B);
                den_reg[i+1] <= den_reg[i];
                sb_reg[i+1]  <= sb_reg[i];
            end
        end
    end

    assign vld_reg[0] = in_valid;
    assign out_valid  = vld_reg[QW];
    assign quot       = q_reg[QW];
    assign side_out   = sb_reg[QW];

endmodule
